### hw/rtl/arm_unwind_opcode_interpreter_macros.svh
// Assertion macros for the unwind opcode interpreter.
`ifndef ARM_UNWIND_OPCODE_INTERPRETER_MACROS_SVH
`define ARM_UNWIND_OPCODE_INTERPRETER_MACROS_SVH
`ifndef SYNTHESIS
`define AUOI_ASSERT_IMPLIES(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: implication");
`define AUOI_ASSERT_NEXT(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: next cycle");
`else
`define AUOI_ASSERT_IMPLIES(name, clk, rst, cond, expr)
`define AUOI_ASSERT_NEXT(name, clk, rst, cond, expr)
`endif
`endif

### hw/rtl/auoi_pkg.sv
// Types and constants shared by the unwind opcode interpreter.
package auoi_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_WORD = 2'd2;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_POPHI = 3'd1;
  localparam logic [2:0] PH_POPLO = 3'd2;
  localparam logic [2:0] PH_ULEB  = 3'd3;
  localparam logic [2:0] PH_WMMXC = 3'd4;
  localparam logic [2:0] PH_MEM   = 3'd5;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [2:0] ERR_REFUSE   = 3'd0;
  localparam logic [2:0] ERR_RESERVED = 3'd1;
  localparam logic [2:0] ERR_MASK     = 3'd2;
  localparam logic [2:0] ERR_CLASS    = 3'd3;
  localparam logic [2:0] ERR_SPARE    = 3'd4;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;

  localparam logic [31:0] ULEB_BIAS = 32'h0000_0204;
  localparam logic [5:0]  ULEB_SHIFT_INIT = 6'd2;
  localparam logic [5:0]  ULEB_SHIFT_MAX = 6'd63;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  reg_index;
    logic [31:0] value;
    logic [7:0]  opcode_byte;
  } item_t;

  typedef struct packed {
    logic [15:0][31:0] regs;
    logic              pc_restored;
    logic [2:0]        phase;
    logic [7:0]        first_byte;
    logic [5:0]        uleb_shift;
    logic [15:0]       pop_mask;
    logic [31:0]       pop_pointer;
  } state_t;

  typedef struct packed {
    logic        emit;
    logic [1:0]  kind;
    logic [31:0] read_address;
    logic [31:0] new_pc;
    logic [31:0] new_sp;
    logic [31:0] new_lr;
    logic [2:0]  error_code;
  } result_t;

endpackage

### hw/rtl/auoi_step.sv
// Next-state and result logic for one interpreter item.
module auoi_step
  import auoi_pkg::*;
(
  input  item_t   item,
  input  state_t  cur,
  output state_t  nxt,
  output result_t res
);

  logic [7:0]  b;
  logic [15:0] low_bit;
  logic [8:0]  sp_off;
  logic [38:0] uleb_wide;
  logic [31:0] uleb_term;
  logic [6:0]  shift_sum;
  logic [31:0] pc_fin;
  logic [15:0] a_mask;

  assign b         = item.opcode_byte;
  assign low_bit   = cur.pop_mask & (~cur.pop_mask + 16'd1);
  assign sp_off    = {1'b0, b[5:0], 2'b00} + 9'd4;
  assign uleb_wide = {32'd0, b[6:0]} << cur.uleb_shift[4:0];
  assign uleb_term = cur.uleb_shift[5] ? 32'd0 : uleb_wide[31:0];
  assign shift_sum = {1'b0, cur.uleb_shift} + 7'd7;
  assign pc_fin    = cur.pc_restored ? cur.regs[REG_PC] : cur.regs[REG_LR];

  always_comb begin
    a_mask = '0;
    for (int i = 0; i < 8; i++) begin
      a_mask[4 + i] = (i[2:0] <= b[2:0]);
    end
    a_mask[REG_LR] = b[3];
  end

  always_comb begin
    logic        do_pop;
    logic [15:0] pop_req;
    logic        fail;
    logic [2:0]  fail_code;
    logic        finish;
    logic [4:0]  cnt;
    nxt       = cur;
    res       = '0;
    do_pop    = 1'b0;
    pop_req   = '0;
    fail      = 1'b0;
    fail_code = ERR_REFUSE;
    finish    = 1'b0;
    cnt       = '0;

    unique case (item.op)
      OP_LOAD: begin
        nxt.regs[item.reg_index] = item.value;
      end
      OP_WORD: begin
        if (cur.phase == PH_MEM) begin
          if (cur.pop_mask != 16'd0) begin
            for (int i = 0; i < 16; i++) begin
              if (low_bit[i]) nxt.regs[i] = item.value;
            end
            nxt.pop_mask    = cur.pop_mask & ~low_bit;
            nxt.pop_pointer = cur.pop_pointer + 32'd4;
          end
          if (nxt.pop_mask != 16'd0) begin
            res.emit         = 1'b1;
            res.kind         = KIND_READ;
            res.read_address = nxt.pop_pointer;
          end else begin
            nxt.phase = PH_IDLE;
          end
        end
      end
      OP_BYTE: begin
        unique case (cur.phase)
          PH_MEM: begin
          end
          PH_POPHI: begin
            nxt.phase = PH_IDLE;
            if (cur.first_byte == 8'h80 && b == 8'h00) begin
              fail      = 1'b1;
              fail_code = ERR_REFUSE;
            end else begin
              do_pop  = 1'b1;
              pop_req = {cur.first_byte[3:0], b, 4'h0};
            end
          end
          PH_POPLO: begin
            nxt.phase = PH_IDLE;
            if (b == 8'h00 || b[7:4] != 4'h0) begin
              fail      = 1'b1;
              fail_code = ERR_MASK;
            end else begin
              do_pop  = 1'b1;
              pop_req = {8'h00, b};
            end
          end
          PH_WMMXC: begin
            fail      = 1'b1;
            fail_code = (b == 8'h00 || b[7:4] != 4'h0) ? ERR_MASK : ERR_CLASS;
          end
          PH_ULEB: begin
            if (b[7]) begin
              nxt.regs[REG_SP] = cur.regs[REG_SP] + uleb_term;
              nxt.uleb_shift   = shift_sum[6] ? ULEB_SHIFT_MAX : shift_sum[5:0];
            end else begin
              nxt.regs[REG_SP] = cur.regs[REG_SP] + uleb_term + ULEB_BIAS;
              nxt.uleb_shift   = ULEB_SHIFT_INIT;
              nxt.phase        = PH_IDLE;
            end
          end
          default: begin
            nxt.phase = PH_IDLE;
            if (!b[7]) begin
              if (b[6]) nxt.regs[REG_SP] = cur.regs[REG_SP] - {23'd0, sp_off};
              else      nxt.regs[REG_SP] = cur.regs[REG_SP] + {23'd0, sp_off};
            end else begin
              unique case (b[6:4])
                3'h0: begin
                  nxt.first_byte = b;
                  nxt.phase      = PH_POPHI;
                end
                3'h1: begin
                  if (b[3:0] == REG_SP || b[3:0] == REG_PC) begin
                    fail      = 1'b1;
                    fail_code = ERR_RESERVED;
                  end else begin
                    nxt.regs[REG_SP] = cur.regs[b[3:0]];
                  end
                end
                3'h2: begin
                  do_pop  = 1'b1;
                  pop_req = a_mask;
                end
                3'h3: begin
                  priority if (b[3:0] == 4'h0) begin
                    finish = 1'b1;
                  end else if (b[3:0] == 4'h1) begin
                    nxt.phase = PH_POPLO;
                  end else if (b[3:0] == 4'h2) begin
                    nxt.uleb_shift = ULEB_SHIFT_INIT;
                    nxt.phase      = PH_ULEB;
                  end else begin
                    fail      = 1'b1;
                    fail_code = ERR_CLASS;
                  end
                end
                3'h4: begin
                  priority if (b[3:0] == 4'h7) begin
                    nxt.phase = PH_WMMXC;
                  end else if (b[3:0] <= 4'h9) begin
                    fail      = 1'b1;
                    fail_code = ERR_CLASS;
                  end else begin
                    fail      = 1'b1;
                    fail_code = ERR_SPARE;
                  end
                end
                3'h5: begin
                  fail      = 1'b1;
                  fail_code = b[3] ? ERR_SPARE : ERR_CLASS;
                end
                default: begin
                  fail      = 1'b1;
                  fail_code = ERR_SPARE;
                end
              endcase
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    for (int i = 0; i < 16; i++) begin
      cnt = cnt + {4'd0, pop_req[i]};
    end

    if (do_pop) begin
      if (pop_req == 16'd0) begin
        nxt.phase = PH_IDLE;
      end else begin
        nxt.pop_pointer = cur.regs[REG_SP];
        if (!pop_req[REG_SP]) nxt.regs[REG_SP] = cur.regs[REG_SP] + {25'd0, cnt, 2'b00};
        if (pop_req[REG_PC]) nxt.pc_restored = 1'b1;
        nxt.pop_mask     = pop_req;
        nxt.phase        = PH_MEM;
        res.emit         = 1'b1;
        res.kind         = KIND_READ;
        res.read_address = cur.regs[REG_SP];
      end
    end

    if (finish) begin
      nxt.regs[REG_PC] = pc_fin;
      res.emit         = 1'b1;
      res.kind         = KIND_DONE;
      res.new_pc       = pc_fin;
      res.new_sp       = cur.regs[REG_SP];
      res.new_lr       = cur.regs[REG_LR];
    end

    if (fail) begin
      res.emit       = 1'b1;
      res.kind       = KIND_FAIL;
      res.error_code = fail_code;
    end

    if (fail || finish) begin
      nxt.phase       = PH_IDLE;
      nxt.pc_restored = 1'b0;
      nxt.uleb_shift  = ULEB_SHIFT_INIT;
      nxt.pop_mask    = '0;
    end
  end

endmodule

### hw/rtl/arm_unwind_opcode_interpreter.sv
// Top level of the unwind opcode interpreter: item register, state and result register.
//
//   channel  | handshake                   | payload
//   item     | item_valid / item_ready     | op, reg_index, value, opcode_byte
//   result   | result_valid / result_ready | kind, read_address, new_pc, new_sp,
//            |                             | new_lr, error_code
//
// One item per cycle unless the result stalls; item register, then result register.
// The decode step between the item register and the state registers sets that rate.
// Reset clears the core registers and the decode state; no clearing pass.
// A stalled result holds back only items that produce a result of their own.
`include "arm_unwind_opcode_interpreter_macros.svh"

module arm_unwind_opcode_interpreter
  import auoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  op,
  input  logic [3:0]  reg_index,
  input  logic [31:0] value,
  input  logic [7:0]  opcode_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [31:0] read_address,
  output logic [31:0] new_pc,
  output logic [31:0] new_sp,
  output logic [31:0] new_lr,
  output logic [2:0]  error_code
);

  logic    item_q_valid;
  item_t   item_q;
  state_t  state;
  state_t  state_next;
  result_t res;
  logic    advance;

  auoi_step u_step (
    .item (item_q),
    .cur  (state),
    .nxt  (state_next),
    .res  (res)
  );

  assign advance    = item_q_valid && (!res.emit || !result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= '{op: op, reg_index: reg_index, value: value, opcode_byte: opcode_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.regs        <= '0;
      state.pc_restored <= 1'b0;
      state.phase       <= PH_IDLE;
      state.first_byte  <= '0;
      state.uleb_shift  <= ULEB_SHIFT_INIT;
      state.pop_mask    <= '0;
      state.pop_pointer <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && res.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      kind         <= res.kind;
      read_address <= res.read_address;
      new_pc       <= res.new_pc;
      new_sp       <= res.new_sp;
      new_lr       <= res.new_lr;
      error_code   <= res.error_code;
    end
  end

  `AUOI_ASSERT_IMPLIES(a_mem_has_mask, clk, rst, state.phase == PH_MEM, state.pop_mask != 16'd0)
  `AUOI_ASSERT_IMPLIES(a_shift_outside_uleb, clk, rst, state.phase != PH_ULEB, state.uleb_shift == ULEB_SHIFT_INIT)
  `AUOI_ASSERT_NEXT(a_item_held, clk, rst, item_q_valid && !advance, item_q_valid)
  `AUOI_ASSERT_IMPLIES(a_kind_known, clk, rst, result_valid, kind == KIND_READ || kind == KIND_DONE || kind == KIND_FAIL)

endmodule
